### rtl/core/lpht_pkg.sv
// lpht_pkg: shared types, codes and field widths for the linear probing hash table
// no dependencies; imported by lpht_home, lpht_probe and linear_probe_hash_table_unit
package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int NAME_AB_W = 64;
    localparam int NAME_C_W  = 32;
    localparam int SLOT_W    = 7;

    // stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 200;
    localparam int M_PAD_W   = M_TDATA_W - (SLOT_W + KEY_W + 2 * NAME_AB_W + NAME_C_W);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [NAME_AB_W-1:0] name_a;
        logic [NAME_AB_W-1:0] name_b;
        logic [NAME_C_W-1:0]  name_c;
    } lpht_rec_t;

    localparam int REC_W = $bits(lpht_rec_t);

    typedef struct packed {
        cmd_t      cmd;
        lpht_rec_t rec;
    } lpht_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        lpht_rec_t         rec;
    } lpht_result_t;

endpackage

### rtl/core/lpht_ram.sv
// lpht_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lpht_home.sv
// lpht_home: home slot of a key, key modulo the table size
// depends on lpht_pkg; a mask for power-of-two sizes, else 4 key bits per cycle
module lpht_home #(
    parameter int TABLE_SIZE = 128,
    localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [IDX_W-1:0]          home
);
    import lpht_pkg::*;

    localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    generate
        if (POW2) begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    home_reg <= key[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_digit
            localparam int VW = IDX_W + 4;
            localparam logic [VW-1:0] TV = VW'(TABLE_SIZE);

            logic             busy_reg, busy_next;
            logic             done_reg, done_next;
            logic [2:0]       cnt_reg, cnt_next;
            logic [31:0]      sh_reg, sh_next;
            logic [IDX_W-1:0] rem_reg, rem_next;
            logic [VW-1:0]    v;

            // remainder step: (rem * 16 + digit) mod size, four conditional subtracts
            always_comb begin
                v = {rem_reg, sh_reg[31:28]};
                for (int i = 3; i >= 0; i--) begin
                    if (v >= (TV << i)) begin
                        v = v - (TV << i);
                    end
                end
            end

            always_comb begin
                busy_next = busy_reg;
                done_next = 1'b0;
                cnt_next  = cnt_reg;
                sh_next   = sh_reg;
                rem_next  = rem_reg;
                if (start) begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    sh_next   = {1'b0, key};
                    rem_next  = '0;
                end else if (busy_reg) begin
                    rem_next = v[IDX_W-1:0];
                    sh_next  = {sh_reg[27:0], 4'b0000};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                end
                cnt_reg <= cnt_next;
                sh_reg  <= sh_next;
                rem_reg <= rem_next;
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule

### rtl/core/lpht_probe.sv
// lpht_probe: clearing pass, probe sequencer and the two table memories
// depends on lpht_pkg, lpht_home and lpht_ram
module lpht_probe #(
    parameter int TABLE_SIZE = 128,
    localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  lpht_pkg::lpht_req_t    req,
    output logic                   res_valid,
    input  logic                   res_ready,
    output lpht_pkg::lpht_result_t res
);
    import lpht_pkg::*;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t       state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    lpht_req_t    req_reg, req_next;
    lpht_result_t res_reg, res_next;

    logic             home_start;
    logic             home_done;
    logic [IDX_W-1:0] home_slot;

    logic             used_we;
    logic [IDX_W-1:0] used_waddr;
    logic             used_wdata;
    logic             used_rdata;
    logic             rec_we;
    logic [IDX_W-1:0] rd_addr;
    logic [REC_W-1:0] rec_rdata;
    lpht_rec_t        rd_rec;

    logic [IDX_W-1:0]        next_addr;
    logic [SLOT_W+IDX_W-1:0] slot_ext;
    logic [SLOT_W-1:0]       slot_bits;

    lpht_home #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_home (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (home_start),
        .key    (req.rec.key),
        .done   (home_done),
        .home   (home_slot)
    );

    lpht_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_SIZE)
    ) u_used_ram (
        .aclk (aclk),
        .we   (used_we),
        .waddr(used_waddr),
        .wdata(used_wdata),
        .raddr(rd_addr),
        .rdata(used_rdata)
    );

    lpht_ram #(
        .WIDTH(REC_W),
        .DEPTH(TABLE_SIZE)
    ) u_rec_ram (
        .aclk (aclk),
        .we   (rec_we),
        .waddr(addr_reg),
        .wdata(req_reg.rec),
        .raddr(rd_addr),
        .rdata(rec_rdata)
    );

    assign rd_rec    = lpht_rec_t'(rec_rdata);
    assign next_addr = (addr_reg == LAST_SLOT) ? '0 : addr_reg + IDX_W'(1);
    assign slot_ext  = {{SLOT_W{1'b0}}, addr_reg};
    assign slot_bits = slot_ext[SLOT_W-1:0];

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        home_start    = 1'b0;
        used_we       = 1'b0;
        used_waddr    = addr_reg;
        used_wdata    = 1'b0;
        rec_we        = 1'b0;
        rd_addr       = next_addr;
        unique case (state_reg)
            S_CLEAR: begin
                used_we       = 1'b1;
                used_waddr    = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req;
                    home_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                rd_addr = home_slot;
                if (home_done) begin
                    addr_next  = home_slot;
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // memory data belongs to addr_reg, next slot is already being read
                addr_next = next_addr;
                cnt_next  = cnt_reg + IDX_W'(1);
                res_next  = '0;
                if (req_reg.cmd == CMD_INSERT) begin
                    if (!used_rdata) begin
                        used_we         = 1'b1;
                        used_wdata      = 1'b1;
                        rec_we          = 1'b1;
                        res_next.status = ST_INSERTED;
                        res_next.slot   = slot_bits;
                        state_next      = S_DONE;
                    end else if (cnt_reg == LAST_SLOT) begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (!used_rdata) begin
                        res_next.status = ST_MISSING;
                        state_next      = S_DONE;
                    end else if (rd_rec.key == req_reg.rec.key) begin
                        res_next.status = ST_FOUND;
                        res_next.slot   = slot_bits;
                        res_next.rec    = rd_rec;
                        state_next      = S_DONE;
                    end else if (cnt_reg == LAST_SLOT) begin
                        res_next.status = ST_MISSING;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

`ifndef SYNTH
    ap_home_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        home_done |-> state_reg == S_HASH)
        else $error("home slot ready outside hash wait");

    ap_found_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg.status == ST_FOUND)
        |-> res_reg.rec.key == req_reg.rec.key)
        else $error("found record key differs from search key");

    ap_write_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_we |-> (req_reg.cmd == CMD_INSERT && used_we && used_wdata && !used_rdata))
        else $error("record write without an empty slot on insert");

    ap_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !res_ready) |=> (state_reg == S_DONE && $stable(res_reg)))
        else $error("pending result lost or changed");
`endif

endmodule

### rtl/core/linear_probe_hash_table_unit.sv
// linear_probe_hash_table_unit: top level of the linear probing hash table
// depends on lpht_pkg and lpht_probe (which holds lpht_home and the lpht_ram memories)
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  --------+-----+-------------------------------------------------+----------------
//  s_      | in  | key, name_part_a, name_part_b, name_part_c, pad | cmd
//  m_      | out | slot, found_key, found_name_a/b/c, pad          | status
//
// the home slot is a key mask for a power-of-two TABLE_SIZE, otherwise built 4 key bits
// a cycle; one slot is probed per cycle through the memory read port, up to TABLE_SIZE
// probes on a full table or a long miss
// after reset a clearing pass over every slot empties the table; s_tready stays low
// one item is worked on at a time; a finished result waits in the m_ output register
// while the next item is taken, and the sequencer stalls only if a second result is ready
module linear_probe_hash_table_unit #(
    parameter int TABLE_SIZE = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpht_pkg::S_TDATA_W-1:0] s_tdata,  // key, name_part_a, name_part_b, name_part_c
    input  logic [0:0]                    s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpht_pkg::M_TDATA_W-1:0] m_tdata,  // slot, found_key, found_name_a/b/c
    output logic [1:0]                    m_tuser   // status
);
    import lpht_pkg::*;

    // field offsets in s_tdata
    localparam int S_A_LO = KEY_W;
    localparam int S_B_LO = KEY_W + NAME_AB_W;
    localparam int S_C_LO = KEY_W + 2 * NAME_AB_W;

    lpht_req_t    req;
    lpht_result_t res;
    logic         res_valid;
    logic         res_ready;

    logic         m_tvalid_reg, m_tvalid_next;
    lpht_result_t out_reg, out_next;

    // unpack the input item
    assign req.cmd         = cmd_t'(s_tuser[0]);
    assign req.rec.key     = s_tdata[KEY_W-1:0];
    assign req.rec.name_a  = s_tdata[S_A_LO +: NAME_AB_W];
    assign req.rec.name_b  = s_tdata[S_B_LO +: NAME_AB_W];
    assign req.rec.name_c  = s_tdata[S_C_LO +: NAME_C_W];

    lpht_probe #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_probe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output register, loads whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    // pack the result item
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.rec.name_c, out_reg.rec.name_b,
                       out_reg.rec.name_a, out_reg.rec.key, out_reg.slot};

`ifndef SYNTH
    ap_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_MISSING)) |-> m_tdata == '0)
        else $error("full or miss result carries nonzero fields");

    ap_insert_no_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_INSERTED) |-> m_tdata[M_TDATA_W-1:SLOT_W] == '0)
        else $error("insert result carries record fields");

    ap_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is at work");
`endif

endmodule

### tb/lpht_checker.sv
// lpht_checker: watches the s_ and m_ channels of the hash table unit, predicts every result
// from its own copy of the table and compares it field by field with what comes out
// depends on lpht_pkg for field widths, command and status codes and record types
module lpht_checker #(
    parameter int TABLE_SIZE = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lpht_pkg::S_TDATA_W-1:0] s_tdata,   // key, name_part_a, name_part_b, name_part_c
    input  logic [0:0]                     s_tuser,   // cmd
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lpht_pkg::M_TDATA_W-1:0] m_tdata,   // slot, found_key, found_name_a/b/c
    input  logic [1:0]                     m_tuser,   // status
    output int                             fail_count,
    output int                             outstanding,
    output int                             n_inserted,
    output int                             n_full,
    output int                             n_found,
    output int                             n_missing
);
    import lpht_pkg::*;

    // bit offsets inside the two tdata buses
    localparam int S_A_LO = KEY_W;
    localparam int S_B_LO = S_A_LO + NAME_AB_W;
    localparam int S_C_LO = S_B_LO + NAME_AB_W;
    localparam int M_K_LO = SLOT_W;
    localparam int M_A_LO = M_K_LO + KEY_W;
    localparam int M_B_LO = M_A_LO + NAME_AB_W;
    localparam int M_C_LO = M_B_LO + NAME_AB_W;

    bit           slot_taken [TABLE_SIZE];
    lpht_rec_t    slot_rec   [TABLE_SIZE];
    lpht_result_t results_due [$];

    // walks the table from the home slot, one slot per step, giving up after a full lap
    task automatic probe_table(input lpht_req_t req, output lpht_result_t res);
        int unsigned idx;
        int          n;
        bit          done;
        idx  = req.rec.key % TABLE_SIZE;
        done = 1'b0;
        res  = '0;
        res.status = (req.cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
        for (n = 0; n < TABLE_SIZE && !done; n++) begin
            if (req.cmd == CMD_INSERT) begin
                if (!slot_taken[idx]) begin
                    slot_taken[idx] = 1'b1;
                    slot_rec[idx]   = req.rec;
                    res.status      = ST_INSERTED;
                    res.slot        = idx[SLOT_W-1:0];
                    done            = 1'b1;
                end
            end else if (!slot_taken[idx]) begin
                done = 1'b1;    // an empty slot ends the chain
            end else if (slot_rec[idx].key == req.rec.key) begin
                res.status = ST_FOUND;
                res.slot   = idx[SLOT_W-1:0];
                res.rec    = slot_rec[idx];
                done       = 1'b1;
            end
            idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        lpht_req_t    req;
        lpht_result_t want;
        lpht_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SIZE; i++) slot_taken[i] = 1'b0;
            results_due.delete();
            fail_count = 0;
            n_inserted = 0;
            n_full     = 0;
            n_found    = 0;
            n_missing  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                req.cmd         = cmd_t'(s_tuser[0]);
                req.rec.key     = s_tdata[0 +: KEY_W];
                req.rec.name_a  = s_tdata[S_A_LO +: NAME_AB_W];
                req.rec.name_b  = s_tdata[S_B_LO +: NAME_AB_W];
                req.rec.name_c  = s_tdata[S_C_LO +: NAME_C_W];
                probe_table(req, want);
                results_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.status     = status_t'(m_tuser);
                got.slot       = m_tdata[0 +: SLOT_W];
                got.rec.key    = m_tdata[M_K_LO +: KEY_W];
                got.rec.name_a = m_tdata[M_A_LO +: NAME_AB_W];
                got.rec.name_b = m_tdata[M_B_LO +: NAME_AB_W];
                got.rec.name_c = m_tdata[M_C_LO +: NAME_C_W];
                if (results_due.size() == 0) begin
                    $display("%0t: result with no item outstanding, expected none, got %h %h",
                             $time, got.status, got.slot);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("slot", want.slot, got.slot);
                    check_field("found_key", want.rec.key, got.rec.key);
                    check_field("found_name_a", want.rec.name_a, got.rec.name_a);
                    check_field("found_name_b", want.rec.name_b, got.rec.name_b);
                    check_field("found_name_c", want.rec.name_c, got.rec.name_c);
                    case (want.status)
                        ST_INSERTED: n_inserted++;
                        ST_FULL:     n_full++;
                        ST_FOUND:    n_found++;
                        default:     n_missing++;
                    endcase
                end
            end
        end
        outstanding <= results_due.size();
    end

endmodule

### tb/tb_top.sv
// tb_top: drives inserts and searches into linear_probe_hash_table_unit with random idling
// on both channels and gives the verdict; prediction and comparison live in lpht_checker
// depends on lpht_pkg, lpht_checker and the unit under test
module tb_top;
    import lpht_pkg::*;

    localparam int TABLE_SIZE = 128;
    localparam int LONG_HOLD  = 400;     // cycles the result side refuses once
    localparam int FILL_ITEMS = 700;     // random items while the table fills up
    localparam int FULL_ITEMS = 1100;    // random items against a full table
    localparam int DRAIN_MAX  = 50000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // key, name_part_a, name_part_b, name_part_c
    logic [0:0]           s_tuser;      // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;      // slot, found_key, found_name_a/b/c
    logic [1:0]           m_tuser;      // status

    int fail_count;
    int outstanding;
    int n_inserted;
    int n_full;
    int n_found;
    int n_missing;

    bit               no_idle;          // both sides run without gaps while set
    bit               hold_request;     // asks the result side for one long hold-off
    int               items_sent;
    logic [KEY_W-1:0] stored_keys [$];  // keys offered for insert, reused by searches

    linear_probe_hash_table_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lpht_checker #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_inserted  (n_inserted),
        .n_full      (n_full),
        .n_found     (n_found),
        .n_missing   (n_missing)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // clustered keys pile up on a few home slots, including both ends of the table
    function automatic logic [KEY_W-1:0] fresh_key(input bit clustered);
        logic [KEY_W-SLOT_W-1:0] upper;
        logic [SLOT_W-1:0]       home;
        upper = (KEY_W-SLOT_W)'($urandom);
        case ($urandom_range(0, 5))
            0:       home = SLOT_W'(0);
            1:       home = SLOT_W'(1);
            2:       home = SLOT_W'(TABLE_SIZE - 2);
            3:       home = SLOT_W'(TABLE_SIZE - 1);
            default: home = SLOT_W'($urandom_range(60, 67));
        endcase
        if (clustered) return {upper, home};
        return KEY_W'($urandom);
    endfunction

    task automatic send_item(input cmd_t op, input logic [KEY_W-1:0] key,
                             input logic [63:0] na, input logic [63:0] nb,
                             input logic [31:0] nc);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, nc, nb, na, key};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == CMD_INSERT) stored_keys.push_back(key);
    endtask

    // searches mostly ask for keys already offered, the rest are likely misses
    task automatic random_item(input int insert_pct);
        int               r;
        logic [KEY_W-1:0] key;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            key = fresh_key($urandom_range(0, 99) < 60);
        else if (r < insert_pct + 15 || stored_keys.size() == 0)
            key = fresh_key($urandom_range(0, 1) == 1);
        else
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        send_item(r < insert_pct ? CMD_INSERT : CMD_SEARCH, key, rand64(), rand64(), $urandom);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        int run;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = idle_cycles();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            run = no_idle ? 50 : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int k;
        int waited;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        aresetn      <= 1'b0;
        hold_request = 1'b0;
        no_idle      = 1'b0;
        items_sent   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, wraparound, duplicates, hits and both kinds of miss
        send_item(CMD_INSERT, '0, '0, '0, '0);
        send_item(CMD_INSERT, '1, '1, '1, '1);                 // home is the last slot
        send_item(CMD_INSERT, 31'd255, 64'h0123_4567_89AB_CDEF,
                  64'hFEDC_BA98_7654_3210, 32'hA5A5_5A5A);     // wraps past the end
        send_item(CMD_SEARCH, 31'd255, '1, '0, '1);
        send_item(CMD_SEARCH, '1, '0, '1, '0);
        send_item(CMD_SEARCH, '0, '0, '0, '0);
        send_item(CMD_INSERT, '0, {16{4'hA}}, {16{4'h5}}, {8{4'hC}});  // duplicate key
        send_item(CMD_SEARCH, '0, '1, '1, '1);                 // first copy wins
        send_item(CMD_SEARCH, 31'd128, '0, '0, '0);            // miss at end of a chain
        send_item(CMD_SEARCH, 31'd5, '0, '0, '0);              // miss at empty home slot
        send_item(CMD_INSERT, 31'h5555_5555, {16{4'h5}}, {16{4'hA}}, {8{4'h5}});
        send_item(CMD_INSERT, 31'h2AAA_AAAA, {16{4'hA}}, {16{4'h5}}, {8{4'hA}});
        send_item(CMD_SEARCH, 31'h5555_5555, '0, '0, '0);
        send_item(CMD_SEARCH, 31'h2AAA_AAAA, '0, '0, '0);
        send_item(CMD_SEARCH, 31'h7FFF_FF7F, '0, '0, '0);      // miss after wrapping
        wait_until_drained();

        // table fills up here; clustered keys build long probe chains
        for (k = 0; k < FILL_ITEMS; k++) begin
            if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (k == 300) hold_request = 1'b1;
            random_item(20);
        end
        wait_until_drained();

        // full table: inserts are refused, misses take a whole lap
        for (k = 0; k < FULL_ITEMS; k++) begin
            if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_item(20);
        end
        s_tvalid <= 1'b0;

        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_MAX);
        repeat (TABLE_SIZE + 16) @(posedge aclk);

        if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
        $display("run: %0d items, %0d stored, %0d refused on a full table",
                 items_sent, n_inserted, n_full);
        $display("run: %0d searches hit, %0d missed, one long result hold-off", n_found, n_missing);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("TB_ERROR");
        $finish;
    end

endmodule
